// ===== src/dds_pkg.sv =====
// dds_pkg: shared constants and types for the decimal digit select block
// no dependencies
`timescale 1ns / 1ps
package dds_pkg;
	localparam int unsigned ValW    = 32;
	localparam int unsigned NumDig  = 10;
	localparam int unsigned BcdW    = 4 * NumDig;
	localparam int unsigned DabSteps = 8;          // shift steps per pipeline stage
	localparam int unsigned DabStages = ValW / DabSteps;

	typedef logic [3:0] nib_t;

	// side data that rides along the conversion stages
	typedef struct packed {
		logic mode;
		nib_t position;
	} side_t;

	// add 3 to every bcd digit that is 5 or more
	function automatic logic [BcdW-1:0] dab_adjust(input logic [BcdW-1:0] b);
		logic [BcdW-1:0] r;
		r = b;
		for (int i = 0; i < NumDig; i++) begin
			if (b[4*i +: 4] >= 4'd5)
				r[4*i +: 4] = b[4*i +: 4] + 4'd3;
		end
		return r;
	endfunction
endpackage

// ===== src/decimal_digit_select_top.sv =====
// decimal_digit_select_top: magnitude, four double dabble stages, digit select
// depends on dds_pkg, dds_dabble_stage, dds_select
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  mode, value, position
// out      output     out_valid / out_stall digit, digit_count
//
// one item enters per cycle while not stalled; registers: magnitude register,
// four stages of eight shift steps each, and the select/output register
// the whole pipeline advances together; out_stall on a valid output freezes every stage
// reset clears the valid bits only
`timescale 1ns / 1ps
module decimal_digit_select_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          mode,
	input  logic [31:0]   value,
	input  logic [3:0]    position,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [3:0]    digit,
	output logic [3:0]    digit_count
);
	logic en;
	logic vld_s0;
	logic [dds_pkg::ValW-1:0] mag_s0;
	dds_pkg::side_t side_s0;

	logic                     vld_s [dds_pkg::DabStages+1];
	logic [dds_pkg::BcdW-1:0] bcd_s [dds_pkg::DabStages+1];
	logic [dds_pkg::ValW-1:0] bin_s [dds_pkg::DabStages+1];
	dds_pkg::side_t           sd_s  [dds_pkg::DabStages+1];

	// stall only when the output holds a result that is not taken
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s0  <= value[31] ? (32'd0 - value) : value;
			side_s0 <= '{mode: mode, position: position};
		end
	end

	assign vld_s[0] = vld_s0;
	assign bcd_s[0] = '0;
	assign bin_s[0] = mag_s0;
	assign sd_s[0]  = side_s0;

	for (genvar g = 0; g < dds_pkg::DabStages; g++) begin : g_dab
		dds_dabble_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld_s[g]),
			.bcd_in  (bcd_s[g]),
			.bin_in  (bin_s[g]),
			.side_in (sd_s[g]),
			.vld_q   (vld_s[g+1]),
			.bcd_q   (bcd_s[g+1]),
			.bin_q   (bin_s[g+1]),
			.side_q  (sd_s[g+1])
		);
	end

	dds_select u_sel (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s[dds_pkg::DabStages]),
		.bcd_in  (bcd_s[dds_pkg::DabStages]),
		.side_in (sd_s[dds_pkg::DabStages]),
		.vld_q   (out_valid),
		.digit_q (digit),
		.count_q (digit_count)
	);
endmodule

// ===== src/dds_dabble_stage.sv =====
// dds_dabble_stage: eight double dabble shift steps followed by a register
// depends on dds_pkg
`timescale 1ns / 1ps
module dds_dabble_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  logic [dds_pkg::BcdW-1:0]    bcd_in,
	input  logic [dds_pkg::ValW-1:0]    bin_in,
	input  dds_pkg::side_t              side_in,
	output logic                        vld_q,
	output logic [dds_pkg::BcdW-1:0]    bcd_q,
	output logic [dds_pkg::ValW-1:0]    bin_q,
	output dds_pkg::side_t              side_q
);
	logic [dds_pkg::BcdW-1:0] bcd_n;
	logic [dds_pkg::ValW-1:0] bin_n;

	always_comb begin
		bcd_n = bcd_in;
		bin_n = bin_in;
		for (int i = 0; i < dds_pkg::DabSteps; i++) begin
			bcd_n = dds_pkg::dab_adjust(bcd_n);
			bcd_n = {bcd_n[dds_pkg::BcdW-2:0], bin_n[dds_pkg::ValW-1]};
			bin_n = {bin_n[dds_pkg::ValW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bcd_q  <= bcd_n;
			bin_q  <= bin_n;
			side_q <= side_in;
		end
	end
endmodule

// ===== src/dds_select.sv =====
// dds_select: digit count and digit selection from the bcd word, registered output
// depends on dds_pkg
`timescale 1ns / 1ps
module dds_select (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic [dds_pkg::BcdW-1:0] bcd_in,
	input  dds_pkg::side_t           side_in,
	output logic                     vld_q,
	output dds_pkg::nib_t            digit_q,
	output dds_pkg::nib_t            count_q
);
	dds_pkg::nib_t cnt;
	dds_pkg::nib_t idx;
	dds_pkg::nib_t sel;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < dds_pkg::NumDig; i++) begin
			if (bcd_in[4*i +: 4] != 4'd0)
				cnt = 4'(i + 1);
		end
		// index from the least significant digit
		if (side_in.mode)
			idx = side_in.position - 4'd1;
		else
			idx = cnt - side_in.position;
		sel = 4'd0;
		if (side_in.position != 4'd0 && side_in.position <= cnt) begin
			for (int i = 0; i < dds_pkg::NumDig; i++) begin
				if (idx == 4'(i))
					sel = bcd_in[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			digit_q <= sel;
			count_q <= cnt;
		end
	end

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> digit_q <= 4'd9) else $error("digit out of range");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> count_q <= 4'd10) else $error("count out of range");
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && count_q == 4'd0 |-> digit_q == 4'd0) else $error("digit without digits");
endmodule

// ===== test/dds_checker.sv =====
// dds_checker: watches both channels of the decimal digit select block,
// predicts each result from the accepted input and compares field by field
`timescale 1ns / 1ps
module dds_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        mode,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  digit,
	input  logic [3:0]  digit_count,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		dds_pkg::nib_t dig;
		dds_pkg::nib_t cnt;
	} digit_res_t;

	digit_res_t want_q[$];

	// digits of the magnitude, least significant first
	function automatic digit_res_t pick_digit(input logic md, input logic [31:0] v,
			input dds_pkg::nib_t pos);
		logic [31:0]   mag;
		dds_pkg::nib_t digs[dds_pkg::NumDig];
		int            n;
		digit_res_t    r;
		mag = v[31] ? (32'd0 - v) : v;
		n = 0;
		while (mag != 0 && n < dds_pkg::NumDig) begin
			digs[n] = dds_pkg::nib_t'(mag % 10);
			mag = mag / 10;
			n++;
		end
		r.cnt = dds_pkg::nib_t'(n);
		r.dig = '0;
		if (pos >= 1 && pos <= n)
			r.dig = md ? digs[pos - 1] : digs[n - pos];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	initial errors = 0;
	assign pending = want_q.size();

	always @(posedge clk) begin
		digit_res_t w;
		if (arst_n) begin
			if (in_valid && !in_stall)
				want_q.push_back(pick_digit(mode, value, position));
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0)
					report_mismatch("result transfer with nothing expected");
				else begin
					w = want_q.pop_front();
					if (digit !== w.dig)
						report_mismatch($sformatf("digit %0d expected %0d", digit, w.dig));
					if (digit_count !== w.cnt)
						report_mismatch($sformatf("digit_count %0d expected %0d",
							digit_count, w.cnt));
				end
			end
		end
	end
endmodule

// ===== test/decimal_digit_select_top_tb.sv =====
// decimal_digit_select_top_tb: directed and random stimulus for the digit select block
// depends on decimal_digit_select_top, dds_checker and dds_pkg
`timescale 1ns / 1ps
module decimal_digit_select_top_tb;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [31:0] value;
	logic [3:0]  position;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  digit;
	logic [3:0]  digit_count;
	int          errors;
	int          pending;
	int          cycles;
	bit          calm;

	decimal_digit_select_top dut (.*);
	dds_checker chk (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls at random except during the calm stretch
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 37);

	function automatic logic [31:0] pick_value();
		int unsigned p10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
			10000000, 100000000, 1000000000};
		int unsigned k;
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = $urandom();
			1: begin
				k = $urandom_range(9);
				v = p10[k] + $urandom_range(2) - 1;
			end
			2: v = $urandom_range(999);
			default: begin
				k = $urandom_range(9);
				v = $urandom() % p10[k] + p10[k];
			end
		endcase
		if ($urandom_range(1))
			v = 32'd0 - v;
		return v;
	endfunction

	task automatic send(input logic md, input logic [31:0] v, input logic [3:0] pos);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= md;
		value    <= v;
		position <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] dir_vals[12] = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd12345,
			32'h7fffffff, 32'h80000000, 32'hffffffff, 32'd1000000000,
			32'd999999999, 32'h80000001, 32'haaaaaaaa};
		cycles    = 0;
		calm      = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = 1'b0;
		value     = '0;
		position  = '0;
		out_stall = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_vals[i])
			send(i[0], dir_vals[i], 4'(i));
		send(1'b0, 32'h80000000, 4'd10);
		send(1'b1, 32'h80000000, 4'd10);
		send(1'b0, 32'd5, 4'd15);
		send(1'b1, 32'h55555555, 4'd11);
		for (int i = 0; i < 2000; i++) begin
			calm = (i >= 800 && i < 1000);
			send($urandom_range(1), pick_value(),
				($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 10)));
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
